// ===== hw/rtl/mrd_pkg.sv =====
// Shared types and constants for the MQTT receive deframer.
package mrd_pkg;

    // Result kinds
    localparam logic [2:0] KIND_IGNORED = 3'd0;
    localparam logic [2:0] KIND_TOPIC   = 3'd1;
    localparam logic [2:0] KIND_MESSAGE = 3'd2;
    localparam logic [2:0] KIND_REPLY   = 3'd3;
    localparam logic [2:0] KIND_CONNACK = 3'd4;
    localparam logic [2:0] KIND_DROPPED = 3'd5;
    localparam logic [2:0] KIND_FRAMING = 3'd6;

    // Control packet types
    localparam logic [3:0] PT_CONNACK = 4'd2;
    localparam logic [3:0] PT_PUBLISH = 4'd3;
    localparam logic [3:0] PT_PUBREC  = 4'd5;
    localparam logic [3:0] PT_PUBREL  = 4'd6;
    localparam logic [3:0] PT_PINGREQ = 4'd12;

    // Reply header bytes
    localparam logic [7:0] HDR_PUBACK  = 8'h40;
    localparam logic [7:0] HDR_PUBREC  = 8'h50;
    localparam logic [7:0] HDR_PUBREL  = 8'h62;
    localparam logic [7:0] HDR_PUBCOMP = 8'h70;
    localparam logic [7:0] REPLY_LEN   = 8'h02;

    // Link drop pairs
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_P    = 8'h50;

    localparam int LEN_W = 28;

    // Extra results that follow the first one of a word
    typedef enum logic [1:0] {
        TAIL_NONE    = 2'd0,
        TAIL_CONNACK = 2'd1,
        TAIL_REPLY   = 2'd2,
        TAIL_DROP    = 2'd3
    } t_tail;

    // One queued command: first result plus the tail to expand
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [3:0]  ptype;
        logic [1:0]  qos;
        logic [15:0] id;
        t_tail       tail;
        logic [7:0]  head;
    } t_cmd;

endpackage

// ===== hw/rtl/mqtt_receive_deframer.sv =====
// Top level of the MQTT receive deframer.
//
// Input channel: a word is taken on a rising edge with push high and full
// low. i_op high is a link-connected event; otherwise i_rx_byte is a byte
// received from the link. Result channel: while empty is low the oldest
// result sits on the o_ ports and leaves on an edge with pop high.
// Each input word yields one to five result words; o_last marks the final
// one of each input word.
//
// The parser takes one word per cycle while full is low and writes one
// command into a QUEUE_DEPTH entry queue in the same cycle. The expander
// loads each command from the queue into its own register when it is
// free. The single expander gives one result word per cycle while pop is
// high; a word that raises a four byte reply yields five result words.
//
// When the receiver stops popping, the held result stays put, the queue
// fills, and full rises once QUEUE_DEPTH commands wait. Synchronous reset
// (i_rst_n low) empties the queue and returns the parser to the header
// phase with the link down; no clearing pass is needed.
module mqtt_receive_deframer #(
    parameter int MAX_LEN_BYTES = 4,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [3:0]  o_packet_type,
    output logic [1:0]  o_qos,
    output logic [15:0] o_message_id,
    output logic [15:0] o_connack_code,
    output logic        o_last
);
    import mrd_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic accept;
    logic q_empty;
    logic q_rd;

    // Word taken only when the queue has room for its command
    assign accept = push && !full;

    mrd_front #(
        .MAX_LEN_BYTES(MAX_LEN_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_op),
        .i_rx_byte(i_rx_byte),
        .o_cmd    (front_cmd)
    );

    mrd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wr_cmd(front_cmd),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_rd_cmd(q_cmd),
        .o_empty (q_empty)
    );

    mrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_cmd       (q_cmd),
        .o_q_rd        (q_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_kind        (o_kind),
        .o_data        (o_data),
        .o_packet_type (o_packet_type),
        .o_qos         (o_qos),
        .o_message_id  (o_message_id),
        .o_connack_code(o_connack_code),
        .o_last        (o_last)
    );

endmodule

// ===== hw/rtl/mrd_front.sv =====
// Front end: parses each word and emits one command record.
module mrd_front #(
    parameter int MAX_LEN_BYTES = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_op,
    input  logic [7:0]    i_rx_byte,
    output mrd_pkg::t_cmd o_cmd
);
    import mrd_pkg::*;

    localparam logic [4:0] LenShiftEnd = 5'(7 * MAX_LEN_BYTES);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

    t_phase             r_phase,     n_phase;
    logic               r_link,      n_link;
    logic [3:0]         r_pkt_kind,  n_pkt_kind;
    logic [1:0]         r_pkt_qos,   n_pkt_qos;
    logic [LEN_W-1:0]   r_remaining, n_remaining;
    logic [4:0]         r_len_shift, n_len_shift;
    logic [LEN_W-1:0]   r_body_pos,  n_body_pos;
    logic [15:0]        r_topic_len, n_topic_len;
    logic [15:0]        r_packet_id, n_packet_id;
    logic [7:0]         r_header,    n_header;

    logic               do_finish;
    logic [LEN_W+6:0]   len_add;
    logic [LEN_W-1:0]   rel;
    logic [LEN_W-1:0]   rel2;
    logic [3:0]         hdr_type;
    t_cmd               cmd;

    assign hdr_type = i_rx_byte[7:4];

    always_comb begin
        n_phase     = r_phase;
        n_link      = r_link;
        n_pkt_kind  = r_pkt_kind;
        n_pkt_qos   = r_pkt_qos;
        n_remaining = r_remaining;
        n_len_shift = r_len_shift;
        n_body_pos  = r_body_pos;
        n_topic_len = r_topic_len;
        n_packet_id = r_packet_id;
        n_header    = r_header;
        do_finish   = 1'b0;
        len_add     = '0;
        rel         = r_body_pos - LEN_W'(2);
        rel2        = rel - LEN_W'(r_topic_len);
        cmd         = '0;
        cmd.kind    = KIND_IGNORED;
        cmd.data    = i_rx_byte;
        cmd.tail    = TAIL_NONE;

        if (i_op) begin
            n_link      = 1'b1;
            n_phase     = PH_HEADER;
            n_remaining = '0;
            n_len_shift = '0;
            n_body_pos  = '0;
            cmd.data    = '0;
        end else if (!r_link) begin
            cmd.kind = KIND_IGNORED;
        end else begin
            case (r_phase)
                PH_LENGTH: begin
                    if (r_remaining == '0 &&
                        ((r_header == CH_C && i_rx_byte == CH_L) ||
                         (r_header == CH_PLUS && i_rx_byte == CH_P))) begin
                        cmd.kind = KIND_DROPPED;
                        n_link   = 1'b0;
                        n_phase  = PH_HEADER;
                    end else begin
                        len_add     = {7'd0, r_remaining}
                                    + ((LEN_W+7)'(i_rx_byte[6:0]) << r_len_shift);
                        n_remaining = len_add[LEN_W-1:0];
                        n_len_shift = r_len_shift + 5'd7;
                        cmd.kind    = KIND_FRAMING;
                        if (!i_rx_byte[7] || n_len_shift >= LenShiftEnd) begin
                            if (n_remaining == '0) begin
                                do_finish = 1'b1;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    n_body_pos = r_body_pos + LEN_W'(1);
                    cmd.kind   = KIND_FRAMING;
                    if (r_pkt_kind == PT_PUBLISH) begin
                        if (r_body_pos == '0) begin
                            n_topic_len = {i_rx_byte, 8'd0};
                        end else if (r_body_pos == LEN_W'(1)) begin
                            n_topic_len = {r_topic_len[15:8], i_rx_byte};
                        end else if (rel < LEN_W'(r_topic_len)) begin
                            cmd.kind = KIND_TOPIC;
                        end else if (r_pkt_qos != 2'd0 && rel2 < LEN_W'(2)) begin
                            if (rel2 == '0) begin
                                n_packet_id = {i_rx_byte, 8'd0};
                            end else begin
                                n_packet_id = {r_packet_id[15:8], i_rx_byte};
                            end
                        end else begin
                            cmd.kind = KIND_MESSAGE;
                        end
                    end else begin
                        if (r_body_pos == '0) begin
                            n_packet_id = {i_rx_byte, 8'd0};
                        end else if (r_body_pos == LEN_W'(1)) begin
                            n_packet_id = {r_packet_id[15:8], i_rx_byte};
                        end
                    end
                    if (n_body_pos >= r_remaining) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    if (hdr_type != 4'd0 && hdr_type != 4'd15) begin
                        n_header    = i_rx_byte;
                        n_pkt_kind  = hdr_type;
                        n_pkt_qos   = i_rx_byte[2:1];
                        n_remaining = '0;
                        n_len_shift = '0;
                        n_body_pos  = '0;
                        n_topic_len = '0;
                        n_packet_id = '0;
                        n_phase     = PH_LENGTH;
                        cmd.kind    = KIND_FRAMING;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
            endcase
        end

        // Packet end: pick the trailing results
        if (do_finish) begin
            n_phase = PH_HEADER;
            case (r_pkt_kind)
                PT_CONNACK: cmd.tail = TAIL_CONNACK;
                PT_PUBLISH: begin
                    if (r_pkt_qos == 2'd1) begin
                        cmd.tail = TAIL_REPLY;
                        cmd.head = HDR_PUBACK;
                    end else if (r_pkt_qos == 2'd2) begin
                        cmd.tail = TAIL_REPLY;
                        cmd.head = HDR_PUBREC;
                    end
                end
                PT_PUBREC: begin
                    cmd.tail = TAIL_REPLY;
                    cmd.head = HDR_PUBREL;
                end
                PT_PUBREL: begin
                    cmd.tail = TAIL_REPLY;
                    cmd.head = HDR_PUBCOMP;
                end
                PT_PINGREQ: begin
                    cmd.tail = TAIL_DROP;
                    n_link   = 1'b0;
                end
                default: cmd.tail = TAIL_NONE;
            endcase
        end

        if (cmd.kind != KIND_IGNORED) begin
            cmd.ptype = n_pkt_kind;
            cmd.qos   = n_pkt_qos;
            cmd.id    = n_packet_id;
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_link      <= 1'b0;
            r_pkt_kind  <= '0;
            r_pkt_qos   <= '0;
            r_remaining <= '0;
            r_len_shift <= '0;
            r_body_pos  <= '0;
            r_topic_len <= '0;
            r_packet_id <= '0;
            r_header    <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_link      <= n_link;
            r_pkt_kind  <= n_pkt_kind;
            r_pkt_qos   <= n_pkt_qos;
            r_remaining <= n_remaining;
            r_len_shift <= n_len_shift;
            r_body_pos  <= n_body_pos;
            r_topic_len <= n_topic_len;
            r_packet_id <= n_packet_id;
            r_header    <= n_header;
        end
    end

endmodule

// ===== hw/rtl/mrd_queue.sv =====
// Small command queue between the parser and the result expander.
module mrd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mrd_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output mrd_pkg::t_cmd o_rd_cmd,
    output logic          o_empty
);
    import mrd_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_wr;
    logic            do_rd;

    assign o_full   = (r_count == CntW'(DEPTH));
    assign o_empty  = (r_count == '0);
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rd_ptr];

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CntW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/mrd_back.sv =====
// Back end: expands each command into its result words.
module mrd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  mrd_pkg::t_cmd i_q_cmd,
    output logic          o_q_rd,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [2:0]    o_kind,
    output logic [7:0]    o_data,
    output logic [3:0]    o_packet_type,
    output logic [1:0]    o_qos,
    output logic [15:0]   o_message_id,
    output logic [15:0]   o_connack_code,
    output logic          o_last
);
    import mrd_pkg::*;

    t_cmd       r_cmd;
    logic       r_valid;
    logic [2:0] r_idx;
    logic [2:0] last_idx;
    logic       is_last;
    logic       load;

    always_comb begin
        case (r_cmd.tail)
            TAIL_NONE:  last_idx = 3'd0;
            TAIL_REPLY: last_idx = 3'd4;
            default:    last_idx = 3'd1;
        endcase
    end

    assign is_last = (r_idx == last_idx);
    assign load    = !r_valid || (i_pop && is_last);
    assign o_q_rd  = load && !i_q_empty;
    assign o_empty = !r_valid;
    assign o_last  = is_last;

    always_comb begin
        o_kind         = r_cmd.kind;
        o_data         = r_cmd.data;
        o_packet_type  = r_cmd.ptype;
        o_qos          = r_cmd.qos;
        o_message_id   = r_cmd.id;
        o_connack_code = '0;
        if (r_idx != 3'd0) begin
            // Tail words always carry packet fields
            o_data = '0;
            case (r_cmd.tail)
                TAIL_CONNACK: begin
                    o_kind         = KIND_CONNACK;
                    o_connack_code = r_cmd.id;
                end
                TAIL_DROP: o_kind = KIND_DROPPED;
                TAIL_REPLY: begin
                    o_kind = KIND_REPLY;
                    case (r_idx)
                        3'd1:    o_data = r_cmd.head;
                        3'd2:    o_data = REPLY_LEN;
                        3'd3:    o_data = r_cmd.id[15:8];
                        default: o_data = r_cmd.id[7:0];
                    endcase
                end
                default: o_kind = r_cmd.kind;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            r_idx   <= '0;
        end else if (i_pop) begin
            r_idx <= r_idx + 3'd1;
        end
    end

endmodule
